>>> hw/rtl/huffman_tree_load_and_decode_assert.svh
// ============================================================================
// Huffman tree loader and decoder: assertion macros
// Short forms for the concurrent checks used in the RTL modules. Each macro
// expects signals named clk and rst_n in the module that uses it.
// ============================================================================
`ifndef HUFFMAN_TREE_LOAD_AND_DECODE_ASSERT_SVH
`define HUFFMAN_TREE_LOAD_AND_DECODE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HTD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HTD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/htd_pkg.sv
// ============================================================================
// Huffman tree loader and decoder: shared package
// Sizes, request and status codes, and the types passed between modules.
// ============================================================================
`default_nettype none

package htd_pkg;

    localparam int SYMBOL_COUNT  = 256;
    localparam int NODE_CAPACITY = 511;
    localparam int STACK_DEPTH   = 256;

    localparam int SYM_W        = 8;
    localparam int SYM_CMP_W    = SYM_W + 1;
    localparam int IDX_W        = $clog2(NODE_CAPACITY);
    localparam int NODE_CNT_W   = $clog2(NODE_CAPACITY + 1);
    localparam int STACK_ADDR_W = $clog2(STACK_DEPTH);
    localparam int LEVEL_W      = $clog2(STACK_DEPTH + 1);
    localparam int PAY_W        = (IDX_W > SYM_W) ? IDX_W : SYM_W;

    // Request selector codes.
    localparam logic [1:0] REQ_INTERNAL = 2'd0;
    localparam logic [1:0] REQ_LEAF     = 2'd1;
    localparam logic [1:0] REQ_BIT      = 2'd2;
    localparam logic [1:0] REQ_NONE     = 2'd3;

    // Result status codes.
    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TREE_ERR = 2'd1;
    localparam logic [1:0] STATUS_NO_TREE  = 2'd2;

    typedef logic [SYM_W-1:0]        sym_t;
    typedef logic [SYM_CMP_W-1:0]    sym_cmp_t;
    typedef logic [IDX_W-1:0]        idx_t;
    typedef logic [NODE_CNT_W-1:0]   cnt_t;
    typedef logic [STACK_ADDR_W-1:0] saddr_t;
    typedef logic [LEVEL_W-1:0]      level_t;
    typedef logic [PAY_W-1:0]        pay_t;

    // One child of an internal node: a leaf with its symbol, or the index
    // of another internal node.
    typedef struct packed {
        logic leaf;
        pay_t payload;
    } htd_desc_t;

    typedef struct packed {
        sym_t       symbol;
        logic [1:0] status;
    } htd_result_t;

    typedef struct packed {
        logic        valid;
        htd_result_t result;
    } htd_res_msg_t;

endpackage

`default_nettype wire

>>> hw/rtl/htd_ram.sv
// ============================================================================
// Huffman tree loader and decoder: generic RAM
// One write port and one read port; the read data is registered, and a
// write to the address being read returns the new data.
// ============================================================================
`default_nettype none

module htd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                        clk,
    input  logic                                        we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                            wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                            rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/htd_core.sv
// ============================================================================
// Huffman tree loader and decoder: tree builder and walker
// Builds the child tables from preorder load items and walks them with
// compressed bits, one item per cycle while accept is high.
// ============================================================================
`default_nettype none
`include "huffman_tree_load_and_decode_assert.svh"

module htd_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  logic [1:0]            req_type,
    input  logic [7:0]            leaf_symbol,
    input  logic                  data_bit,
    output htd_pkg::htd_res_msg_t res_msg
);

    htd_pkg::cnt_t   nodes_used_reg, nodes_used_next;
    htd_pkg::level_t level_reg, level_next;
    htd_pkg::idx_t   top_idx_reg, top_idx_next;
    logic            top_ld_reg, top_ld_next;
    htd_pkg::idx_t   walk_pos_reg, walk_pos_next;
    logic            tree_complete_reg, tree_complete_next;
    logic            tree_broken_reg, tree_broken_next;
    logic            root_leaf_reg, root_leaf_next;

    logic              is_load;
    logic              clear;
    htd_pkg::cnt_t     eff_used;
    htd_pkg::level_t   eff_level;
    htd_pkg::level_t   level_dec;
    htd_pkg::level_t   level_after;
    htd_pkg::level_t   level_rd;
    logic              have_parent;
    logic              load_err;
    htd_pkg::idx_t     node_idx;
    htd_pkg::htd_desc_t new_desc;
    htd_pkg::htd_desc_t left_rd, right_rd, child;
    logic              left_we, right_we;
    logic              stk_we;
    htd_pkg::saddr_t   stk_waddr, stk_raddr;
    htd_pkg::idx_t     stk_rd;

    // Each internal node keeps its two children in two tables, so a child is
    // attached with a single write and no read of the parent.
    htd_ram #(
        .WIDTH ($bits(htd_pkg::htd_desc_t)),
        .DEPTH (htd_pkg::NODE_CAPACITY)
    ) u_left_ram (
        .clk   (clk),
        .we    (left_we),
        .waddr (top_idx_reg),
        .wdata (new_desc),
        .raddr (walk_pos_next),
        .rdata (left_rd)
    );

    htd_ram #(
        .WIDTH ($bits(htd_pkg::htd_desc_t)),
        .DEPTH (htd_pkg::NODE_CAPACITY)
    ) u_right_ram (
        .clk   (clk),
        .we    (right_we),
        .waddr (top_idx_reg),
        .wdata (new_desc),
        .raddr (walk_pos_next),
        .rdata (right_rd)
    );

    // The top of the open-node stack lives in registers; the RAM holds the
    // entries below it, all of which already have their left child.
    htd_ram #(
        .WIDTH (htd_pkg::IDX_W),
        .DEPTH (htd_pkg::STACK_DEPTH)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (top_idx_reg),
        .raddr (stk_raddr),
        .rdata (stk_rd)
    );

    assign is_load     = (req_type == htd_pkg::REQ_INTERNAL) || (req_type == htd_pkg::REQ_LEAF);
    assign clear       = is_load && (tree_complete_reg || tree_broken_reg);
    assign eff_used    = clear ? '0 : nodes_used_reg;
    assign eff_level   = clear ? '0 : level_reg;
    assign level_dec   = eff_level - htd_pkg::level_t'(1);
    assign have_parent = (eff_level != '0);
    assign level_after = (have_parent && top_ld_reg) ? level_dec : eff_level;
    assign node_idx    = eff_used[htd_pkg::IDX_W-1:0];
    assign stk_waddr   = level_dec[htd_pkg::STACK_ADDR_W-1:0];
    assign level_rd    = level_next - htd_pkg::level_t'(2);
    assign stk_raddr   = level_rd[htd_pkg::STACK_ADDR_W-1:0];
    assign child       = data_bit ? right_rd : left_rd;

    assign load_err =
        (eff_used == htd_pkg::cnt_t'(htd_pkg::NODE_CAPACITY)) ||
        ((req_type == htd_pkg::REQ_LEAF) &&
         (htd_pkg::sym_cmp_t'(leaf_symbol) >= htd_pkg::sym_cmp_t'(htd_pkg::SYMBOL_COUNT))) ||
        ((req_type == htd_pkg::REQ_INTERNAL) &&
         (level_after >= htd_pkg::level_t'(htd_pkg::STACK_DEPTH)));

    always_comb
    begin
        new_desc.leaf    = (req_type == htd_pkg::REQ_LEAF);
        new_desc.payload = new_desc.leaf ? htd_pkg::pay_t'(leaf_symbol)
                                         : htd_pkg::pay_t'(node_idx);
    end

    always_comb
    begin
        nodes_used_next    = nodes_used_reg;
        level_next         = level_reg;
        top_idx_next       = top_idx_reg;
        top_ld_next        = top_ld_reg;
        walk_pos_next      = walk_pos_reg;
        tree_complete_next = tree_complete_reg;
        tree_broken_next   = tree_broken_reg;
        root_leaf_next     = root_leaf_reg;
        left_we            = 1'b0;
        right_we           = 1'b0;
        stk_we             = 1'b0;
        res_msg            = '0;

        if (accept)
        begin
            unique case (req_type) inside
                htd_pkg::REQ_INTERNAL, htd_pkg::REQ_LEAF:
                begin
                    // A load item after a finished or broken tree starts over.
                    if (clear)
                    begin
                        tree_complete_next = 1'b0;
                        tree_broken_next   = 1'b0;
                        walk_pos_next      = '0;
                    end
                    nodes_used_next = eff_used;
                    level_next      = eff_level;

                    if (load_err)
                    begin
                        tree_broken_next      = 1'b1;
                        res_msg.valid         = 1'b1;
                        res_msg.result.status = htd_pkg::STATUS_TREE_ERR;
                    end
                    else
                    begin
                        nodes_used_next = eff_used + htd_pkg::cnt_t'(1);
                        if (eff_used == '0)
                        begin
                            root_leaf_next = (req_type == htd_pkg::REQ_LEAF);
                        end
                        if (have_parent)
                        begin
                            right_we = top_ld_reg;
                            left_we  = !top_ld_reg;
                        end

                        if (req_type == htd_pkg::REQ_INTERNAL)
                        begin
                            top_idx_next = node_idx;
                            top_ld_next  = 1'b0;
                            if (!have_parent)
                            begin
                                level_next = htd_pkg::level_t'(1);
                            end
                            else if (!top_ld_reg)
                            begin
                                // Old top moves into the RAM with its left child set.
                                stk_we     = 1'b1;
                                level_next = eff_level + htd_pkg::level_t'(1);
                            end
                        end
                        else
                        begin
                            if (have_parent)
                            begin
                                if (top_ld_reg)
                                begin
                                    top_idx_next = stk_rd;
                                    top_ld_next  = 1'b1;
                                    level_next   = level_dec;
                                end
                                else
                                begin
                                    top_ld_next = 1'b1;
                                end
                            end
                            if (!have_parent || (top_ld_reg && (level_dec == '0)))
                            begin
                                tree_complete_next = 1'b1;
                                walk_pos_next      = '0;
                            end
                        end
                    end
                end
                htd_pkg::REQ_BIT:
                begin
                    if (!tree_complete_reg)
                    begin
                        res_msg.valid         = 1'b1;
                        res_msg.result.status = htd_pkg::STATUS_NO_TREE;
                    end
                    else if (!root_leaf_reg)
                    begin
                        if (child.leaf)
                        begin
                            res_msg.valid         = 1'b1;
                            res_msg.result.symbol = child.payload[htd_pkg::SYM_W-1:0];
                            res_msg.result.status = htd_pkg::STATUS_OK;
                            walk_pos_next         = '0;
                        end
                        else
                        begin
                            walk_pos_next = child.payload[htd_pkg::IDX_W-1:0];
                        end
                    end
                end
                htd_pkg::REQ_NONE:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_used_reg    <= '0;
            level_reg         <= '0;
            top_idx_reg       <= '0;
            top_ld_reg        <= 1'b0;
            walk_pos_reg      <= '0;
            tree_complete_reg <= 1'b0;
            tree_broken_reg   <= 1'b0;
            root_leaf_reg     <= 1'b0;
        end
        else
        begin
            nodes_used_reg    <= nodes_used_next;
            level_reg         <= level_next;
            top_idx_reg       <= top_idx_next;
            top_ld_reg        <= top_ld_next;
            walk_pos_reg      <= walk_pos_next;
            tree_complete_reg <= tree_complete_next;
            tree_broken_reg   <= tree_broken_next;
            root_leaf_reg     <= root_leaf_next;
        end
    end

    `HTD_ASSERT_IMPL(a_complete_has_empty_stack, tree_complete_reg, (level_reg == '0) && !tree_broken_reg, "complete tree with open nodes or broken flag")
    `HTD_ASSERT_IMPL(a_walk_inside_tree, walk_pos_reg != '0, htd_pkg::cnt_t'(walk_pos_reg) < nodes_used_reg, "walk position beyond loaded nodes")
    `HTD_ASSERT_NEXT(a_error_breaks_tree, res_msg.valid && (res_msg.result.status == htd_pkg::STATUS_TREE_ERR), tree_broken_reg && !tree_complete_reg, "tree error did not mark the tree broken")

endmodule

`default_nettype wire

>>> hw/rtl/htd_out_buf.sv
// ============================================================================
// Huffman tree loader and decoder: result buffer
// Output register plus a skid entry, so the core can take one more item
// while a result waits on the output.
// ============================================================================
`default_nettype none
`include "huffman_tree_load_and_decode_assert.svh"

module htd_out_buf (
    input  logic                  clk,
    input  logic                  rst_n,
    input  htd_pkg::htd_res_msg_t push_msg,
    input  logic                  res_ready,
    output logic                  res_valid,
    output htd_pkg::htd_result_t  res_data,
    output logic                  buf_ready
);

    logic                 main_valid_reg, main_valid_next;
    htd_pkg::htd_result_t main_reg, main_next;
    logic                 skid_valid_reg, skid_valid_next;
    htd_pkg::htd_result_t skid_reg, skid_next;
    logic                 take;

    assign take      = main_valid_reg && res_ready;
    assign buf_ready = !skid_valid_reg;
    assign res_valid = main_valid_reg;
    assign res_data  = main_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        main_next       = main_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;

        if (skid_valid_reg)
        begin
            if (take)
            begin
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!main_valid_reg || take)
        begin
            main_valid_next = push_msg.valid;
            main_next       = push_msg.result;
        end
        else if (push_msg.valid)
        begin
            skid_valid_next = 1'b1;
            skid_next       = push_msg.result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    `HTD_ASSERT_IMPL(a_skid_behind_main, skid_valid_reg, main_valid_reg, "skid entry held without an output entry")
    `HTD_ASSERT_IMPL(a_no_push_when_full, push_msg.valid, !skid_valid_reg, "result pushed into a full buffer")

endmodule

`default_nettype wire

>>> hw/rtl/huffman_tree_load_and_decode.sv
// ============================================================================
// Huffman tree loader and decoder
// Loads a preorder-serialized Huffman tree and decodes compressed bits by
// walking it, one symbol per leaf reached.
// ============================================================================
//
//  Channel | Handshake            | Fields                          | Dir
//  --------+----------------------+---------------------------------+-----
//  req     | req_valid/req_ready  | req_type, leaf_symbol, data_bit | in
//  res     | res_valid/res_ready  | symbol, status                  | out
//
// One item is taken per cycle while req_ready is high, load items and data
// bits alike. The child tables are read at the next walk position every
// cycle, so the node for a data bit is already in the read register when
// that bit arrives. Each result is registered before it appears on res.
// Reset clears only the counters and flags; the tables need no clearing
// pass, so items are accepted from the first cycle after reset.
// A stalled res channel is absorbed by a one-entry skid; req_ready drops
// only once both the output register and the skid entry hold results.
//
// The tree is built in preorder. Each internal node stores its left and
// right child in two separate tables, as either a leaf symbol or a node
// index, so attaching a child is one write and decoding a bit needs one
// read. Internal nodes still waiting for a child sit on a stack whose top
// is held in registers; the entries below the top always have their left
// child and are kept in a small RAM, prefetched one level down so a pop
// completes in the same cycle. A tree is complete when the stack empties;
// the next load item after a complete or broken tree starts a fresh one.
// ============================================================================
`default_nettype none

module huffman_tree_load_and_decode (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       req_valid,
    output logic       req_ready,
    input  logic [1:0] req_type,
    input  logic [7:0] leaf_symbol,
    input  logic       data_bit,
    output logic       res_valid,
    input  logic       res_ready,
    output logic [7:0] symbol,
    output logic [1:0] status
);

    logic                  accept;
    htd_pkg::htd_res_msg_t core_msg;
    htd_pkg::htd_result_t  res_data;

    // An item enters the core when req_valid is high and the buffer has room.
    assign accept = req_valid && req_ready;

    htd_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .req_type    (req_type),
        .leaf_symbol (leaf_symbol),
        .data_bit    (data_bit),
        .res_msg     (core_msg)
    );

    htd_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_msg  (core_msg),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res_data  (res_data),
        .buf_ready (req_ready)
    );

    // The symbol field is zero for every status other than a decoded symbol.
    assign symbol = res_data.symbol;
    assign status = res_data.status;

endmodule

`default_nettype wire
